FILE: sv/vsc_pkg.sv
`timescale 1ns / 1ps
// vsc_pkg: shared types and constants for the vigenere stream cipher
// no dependencies; imported by vsc_xform, vigenere_stream_cipher and tb_top

package vsc_pkg;

   // key geometry
   localparam int KEY_MAX       = 16;
   localparam int KEY_IDX_W     = $clog2(KEY_MAX);
   localparam int KEY_LEN_W     = 5;
   localparam int SHIFT_W       = 5;
   localparam int SHIFT_REG_W   = 40;
   localparam int SHIFTS_ALL_W  = 2 * SHIFT_REG_W;

   // character handling
   localparam int CHAR_W        = 8;
   localparam int LETTER_W      = 5;
   localparam logic [LETTER_W-1:0] ALPHA_SIZE = LETTER_W'(26);
   localparam logic [CHAR_W-1:0] CHAR_UP_A  = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UP_Z  = 8'h5A;
   localparam logic [CHAR_W-1:0] CHAR_LO_A  = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LO_Z  = 8'h7A;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CASE_DELTA = 8'h20;

   // configuration port
   localparam int CSR_DATA_W    = 64;
   localparam int CSR_ADDR_W    = 5;

   typedef enum logic [1:0] {
      REG_MODE        = 2'd0,
      REG_KEY_LENGTH  = 2'd1,
      REG_SHIFTS_LOW  = 2'd2,
      REG_SHIFTS_HIGH = 2'd3
   } csr_reg_type;

   localparam logic MODE_ENCRYPT = 1'b0;
   localparam logic MODE_DECRYPT = 1'b1;

   typedef struct packed {
      logic                   mode;
      logic [KEY_LEN_W-1:0]   key_length;
      logic [SHIFT_REG_W-1:0] key_shifts_low;
      logic [SHIFT_REG_W-1:0] key_shifts_high;
   } cfg_type;

   typedef struct packed {
      logic [CHAR_W-1:0]    out_char;
      logic                 emit;
      logic [KEY_IDX_W-1:0] key_index_next;
   } xform_type;

endpackage

FILE: sv/vsc_xform.sv
`timescale 1ns / 1ps
// vsc_xform: per-character transform and key position update, pure logic
// depends on vsc_pkg

module vsc_xform (
   input  logic [vsc_pkg::CHAR_W-1:0]    in_char,
   input  logic                          in_last,
   input  logic [vsc_pkg::KEY_IDX_W-1:0] key_index,
   input  vsc_pkg::cfg_type              cfg,
   output vsc_pkg::xform_type            result
);
   import vsc_pkg::*;

   logic [CHAR_W-1:0]       folded;
   logic                    is_digit;
   logic                    is_upper;
   logic [SHIFTS_ALL_W-1:0] shifts_all;
   logic [SHIFT_W-1:0]      shift_raw;
   logic [LETTER_W-1:0]     shift_mod;
   logic [LETTER_W-1:0]     letter;
   logic [LETTER_W:0]       sum;
   logic [LETTER_W-1:0]     shifted;
   logic [KEY_LEN_W-1:0]    eff_len;
   logic [KEY_LEN_W-1:0]    idx_inc;
   logic [KEY_IDX_W-1:0]    idx_adv;
   logic [KEY_IDX_W-1:0]    idx_keep;

   // fold lowercase to uppercase
   always_comb begin
      if (in_char >= CHAR_LO_A && in_char <= CHAR_LO_Z) begin
         folded = in_char - CASE_DELTA;
      end else begin
         folded = in_char;
      end
   end

   assign is_digit = (folded >= CHAR_ZERO) && (folded <= CHAR_NINE);
   assign is_upper = (folded >= CHAR_UP_A) && (folded <= CHAR_UP_Z);

   // shift at current position, reduced mod 26 (raw is at most 31)
   assign shifts_all = {cfg.key_shifts_high, cfg.key_shifts_low};
   assign shift_raw  = shifts_all[SHIFT_W*key_index +: SHIFT_W];
   assign shift_mod  = (shift_raw >= ALPHA_SIZE) ? (shift_raw - ALPHA_SIZE) : shift_raw;

   assign letter = LETTER_W'(folded - CHAR_UP_A);

   always_comb begin
      if (cfg.mode == MODE_DECRYPT) begin
         if (letter >= shift_mod) begin
            sum = {1'b0, letter} - {1'b0, shift_mod};
         end else begin
            sum = {1'b0, letter} + {1'b0, ALPHA_SIZE} - {1'b0, shift_mod};
         end
      end else begin
         sum = {1'b0, letter} + {1'b0, shift_mod};
         if (sum >= {1'b0, ALPHA_SIZE}) begin
            sum = sum - {1'b0, ALPHA_SIZE};
         end
      end
   end
   assign shifted = sum[LETTER_W-1:0];

   // effective key length, clamped to 1..KEY_MAX
   always_comb begin
      if (cfg.key_length == '0) begin
         eff_len = KEY_LEN_W'(1);
      end else if (cfg.key_length > KEY_LEN_W'(KEY_MAX)) begin
         eff_len = KEY_LEN_W'(KEY_MAX);
      end else begin
         eff_len = cfg.key_length;
      end
   end

   assign idx_inc = KEY_LEN_W'(key_index) + KEY_LEN_W'(1);
   assign idx_adv = (idx_inc >= eff_len) ? '0 : idx_inc[KEY_IDX_W-1:0];

   always_comb begin
      result.out_char = '0;
      result.emit     = 1'b0;
      idx_keep        = key_index;
      if (is_digit) begin
         result.out_char = folded;
         result.emit     = 1'b1;
         idx_keep        = idx_adv;
      end else if (is_upper) begin
         result.out_char = CHAR_UP_A + CHAR_W'(shifted);
         result.emit     = 1'b1;
         idx_keep        = idx_adv;
      end
      result.key_index_next = in_last ? '0 : idx_keep;
   end

endmodule

FILE: sv/vigenere_stream_cipher.sv
`timescale 1ns / 1ps
// vigenere_stream_cipher: top level, stream ports, csr block and pipeline
// depends on vsc_pkg and vsc_xform
//
// Vigenere cipher on a character stream. Each req transfer carries one
// byte in tdata and an end-of-string mark in tlast; each produces exactly
// one rsp transfer: tdata holds the uppercase cipher letter or the digit,
// tuser is the emit flag (0 for a skipped character, tdata then 0) and
// tlast copies the input mark. Letters of either case are shifted by the
// key shift at the current key position (add to encrypt, subtract to
// decrypt, mod 26); letters and digits advance the position, which wraps
// at key_length and restarts after every tlast. Throughput is one
// character per clock while rsp_tready stays high: an input register
// feeds one level of transform logic into the result register, and both
// stages keep moving while the next character arrives. Registers sit at
// byte addresses 0 (mode), 8 (key_length), 16 (key shifts 0-7) and 24
// (key shifts 8-15), 64-bit data, five bits per shift with shift i in
// bits 5i+4..5i. Write configuration only while the stream is idle.

module vigenere_stream_cipher (
   input  logic                           clock,
   input  logic                           reset,
   // input stream
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,   // [7:0] in_char
   input  logic                           req_tlast,   // in_last
   // result stream
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [7:0]                     rsp_tdata,   // [7:0] out_char
   output logic                           rsp_tuser,   // [0] emit
   output logic                           rsp_tlast,   // out_last
   // configuration port
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [vsc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [vsc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [vsc_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import vsc_pkg::*;

   // configuration registers
   cfg_type              cfg_ff;
   csr_reg_type          csr_sel;
   logic                 csr_wr;

   // input stage
   logic                 in_valid_ff;
   logic [CHAR_W-1:0]    in_char_ff;
   logic                 in_last_ff;

   // result stage
   logic                 out_valid_ff;
   logic [CHAR_W-1:0]    out_char_ff;
   logic                 out_emit_ff;
   logic                 out_last_ff;

   // key position
   logic [KEY_IDX_W-1:0] key_index_ff;
   logic [KEY_IDX_W-1:0] key_index_in;

   logic                 out_load;
   xform_type            xform;

   // ---------------------------------------------------------------
   // csr block: register index from 8-byte address slots
   // ---------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_sel    = csr_reg_type'(csr_paddr[CSR_ADDR_W-1:3]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode            <= MODE_ENCRYPT;
         cfg_ff.key_length      <= KEY_LEN_W'(1);
         cfg_ff.key_shifts_low  <= '0;
         cfg_ff.key_shifts_high <= '0;
      end else if (csr_wr) begin
         case (csr_sel)
            REG_MODE: begin
               cfg_ff.mode <= csr_pwdata[0];
            end
            REG_KEY_LENGTH: begin
               cfg_ff.key_length <= csr_pwdata[KEY_LEN_W-1:0];
            end
            REG_SHIFTS_LOW: begin
               cfg_ff.key_shifts_low <= csr_pwdata[SHIFT_REG_W-1:0];
            end
            REG_SHIFTS_HIGH: begin
               cfg_ff.key_shifts_high <= csr_pwdata[SHIFT_REG_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // read back
   always_comb begin
      case (csr_sel)
         REG_MODE:        csr_prdata = CSR_DATA_W'(cfg_ff.mode);
         REG_KEY_LENGTH:  csr_prdata = CSR_DATA_W'(cfg_ff.key_length);
         REG_SHIFTS_LOW:  csr_prdata = CSR_DATA_W'(cfg_ff.key_shifts_low);
         REG_SHIFTS_HIGH: csr_prdata = CSR_DATA_W'(cfg_ff.key_shifts_high);
         default:         csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------
   // pipeline control: result register loads from a full input register when
   // empty or draining, input register refills when empty or its content moves on
   // ---------------------------------------------------------------
   assign out_load   = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || out_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_char_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   // transform of the character in the input register
   vsc_xform u_xform (
      .in_char   (in_char_ff),
      .in_last   (in_last_ff),
      .key_index (key_index_ff),
      .cfg       (cfg_ff),
      .result    (xform)
   );

   // key position moves only when its character moves into the result stage
   assign key_index_in = out_load ? xform.key_index_next : key_index_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_index_ff <= '0;
      end else begin
         key_index_ff <= key_index_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_char_ff <= xform.out_char;
         out_emit_ff <= xform.emit;
         out_last_ff <= in_last_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_char_ff;
   assign rsp_tuser  = out_emit_ff;
   assign rsp_tlast  = out_last_ff;

`ifndef ASSERT_OFF
   // end of string restarts the key position
   a_last_restarts_key: assert property (@(posedge clock) disable iff (reset)
      out_load && in_last_ff |=> key_index_ff == '0)
      else $error("key position not cleared after end of string");

   // skipped character carries a zero byte
   a_skip_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("skipped character with nonzero data");

   // emitted byte is an uppercase letter or a digit
   a_emit_class: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |->
         (rsp_tdata >= CHAR_UP_A && rsp_tdata <= CHAR_UP_Z) ||
         (rsp_tdata >= CHAR_ZERO && rsp_tdata <= CHAR_NINE))
      else $error("emitted character outside letter and digit range");

   // key position never moves without a character entering the result stage
   a_key_hold: assert property (@(posedge clock) disable iff (reset)
      !out_load |=> $stable(key_index_ff))
      else $error("key position changed with no transfer");
`endif

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking testbench for vigenere_stream_cipher
// depends on vsc_pkg and the vigenere_stream_cipher rtl; reads no files

module tb_top;
   import vsc_pkg::*;

   localparam int CYCLE_LIMIT = 200000;

   // one character headed for the req channel
   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              last;
   } char_xfer_type;

   // one expected rsp transfer
   typedef struct packed {
      logic [CHAR_W-1:0] text;
      logic              emit;
      logic              last;
   } cipher_out_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata = '0;
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [7:0]            rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // predictor state: register copy and key position
   cfg_type              key_cfg = '{mode: MODE_ENCRYPT, key_length: 5'd1, default: '0};
   logic [KEY_IDX_W-1:0] key_pos = '0;

   char_xfer_type  plain_queue[$];   // characters waiting to be sent
   cipher_out_type cipher_due[$];    // predicted results not yet seen

   int unsigned cycle_count = 0;
   int unsigned fail_count = 0;
   int unsigned sent_count = 0;
   int unsigned emitted_count = 0;
   int unsigned skipped_count = 0;
   int unsigned setting_count = 0;

   vigenere_stream_cipher DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),    // [7:0] in_char
      .req_tlast   (req_tlast),    // in_last
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),    // [7:0] out_char
      .rsp_tuser   (rsp_tuser),    // [0] emit
      .rsp_tlast   (rsp_tlast),    // out_last
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #1 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d results outstanding",
                   $time, cycle_count, cipher_due.size());
         $display("FAILURE");
         $finish;
      end
   end

   // predict one result and move the key position like the block should
   function automatic cipher_out_type cipher_predict(input logic [CHAR_W-1:0] ch_in,
                                                     input logic last);
      logic [CHAR_W-1:0]       ch;
      logic [SHIFTS_ALL_W-1:0] all_shifts;
      logic                    step;
      int                      len;
      int                      shift_amt;
      int                      letter;
      cipher_out_type          res;
      ch = ch_in;
      step = 1'b0;
      res = '0;
      res.last = last;
      // lowercase folds to uppercase first
      if (ch >= CHAR_LO_A && ch <= CHAR_LO_Z)
         ch = ch - CASE_DELTA;
      if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
         // digits pass through but still use up a key position
         res.text = ch;
         res.emit = 1'b1;
         step = 1'b1;
      end else if (ch >= CHAR_UP_A && ch <= CHAR_UP_Z) begin
         all_shifts = {key_cfg.key_shifts_high, key_cfg.key_shifts_low};
         // raw shifts of 26..31 wrap back into range
         shift_amt = int'(all_shifts[key_pos*SHIFT_W +: SHIFT_W]) % int'(ALPHA_SIZE);
         letter = int'(ch - CHAR_UP_A);
         if (key_cfg.mode == MODE_DECRYPT)
            letter = (letter + int'(ALPHA_SIZE) - shift_amt) % int'(ALPHA_SIZE);
         else
            letter = (letter + shift_amt) % int'(ALPHA_SIZE);
         res.text = CHAR_UP_A + CHAR_W'(letter);
         res.emit = 1'b1;
         step = 1'b1;
      end
      if (step) begin
         // zero length acts as one, oversize saturates at the key size
         len = int'(key_cfg.key_length);
         if (len == 0)
            len = 1;
         if (len > KEY_MAX)
            len = KEY_MAX;
         // a position already past a shortened length still wraps to zero
         key_pos = (int'(key_pos) + 1 >= len) ? '0 : key_pos + 1'b1;
      end
      if (last)
         key_pos = '0;
      return res;
   endfunction

   // sender: bursts of random length, random gaps, sometimes none at all
   int unsigned burst_left = 0;
   int unsigned gap_left = 0;

   always @(posedge clock) begin
      char_xfer_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
         burst_left <= 0;
         gap_left <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (gap_left != 0 || plain_queue.size() == 0) begin
            req_tvalid <= 1'b0;
            if (gap_left != 0)
               gap_left <= gap_left - 1;
         end else begin
            item = plain_queue.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= item.ch;
            req_tlast <= item.last;
            if (burst_left != 0) begin
               burst_left <= burst_left - 1;
            end else begin
               burst_left <= $urandom_range(0, 30);
               gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
         end
      end
   end

   // receiver: switches between random stall styles
   int unsigned stall_left = 0;
   int unsigned stall_style = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (stall_left == 0) begin
            stall_style <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 120);
         end else begin
            stall_left <= stall_left - 1;
         end
         case (stall_style)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom_range(0, 1));
            2: rsp_tready <= ($urandom_range(0, 3) == 0);
            default: rsp_tready <= cycle_count[2];
         endcase
      end
   end

   // monitor: predict on each req transfer, check each rsp transfer
   always @(posedge clock) begin
      cipher_out_type want;
      if (reset) begin
         key_pos = '0;
      end else begin
         if (req_tvalid && req_tready) begin
            cipher_due.insert(cipher_due.size(), cipher_predict(req_tdata, req_tlast));
            sent_count++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (cipher_due.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual tdata %h tuser %b tlast %b",
                        $time, rsp_tdata, rsp_tuser, rsp_tlast);
               fail_count++;
            end else begin
               want = cipher_due.pop_front();
               if (rsp_tdata !== want.text) begin
                  $display("%0t: out_char mismatch, expected %h actual %h",
                           $time, want.text, rsp_tdata);
                  fail_count++;
               end
               if (rsp_tuser !== want.emit) begin
                  $display("%0t: emit mismatch, expected %b actual %b",
                           $time, want.emit, rsp_tuser);
                  fail_count++;
               end
               if (rsp_tlast !== want.last) begin
                  $display("%0t: out_last mismatch, expected %b actual %b",
                           $time, want.last, rsp_tlast);
                  fail_count++;
               end
               if (want.emit)
                  emitted_count++;
               else
                  skipped_count++;
            end
         end
      end
   end

   // setup and access cycle, then mirror the write into the predictor
   task automatic csr_write(input csr_reg_type idx, input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 3'b000};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_MODE:        key_cfg.mode = value[0];
         REG_KEY_LENGTH:  key_cfg.key_length = value[KEY_LEN_W-1:0];
         REG_SHIFTS_LOW:  key_cfg.key_shifts_low = value[SHIFT_REG_W-1:0];
         REG_SHIFTS_HIGH: key_cfg.key_shifts_high = value[SHIFT_REG_W-1:0];
         default: ;
      endcase
   endtask

   task automatic key_setup(input logic md, input logic [KEY_LEN_W-1:0] len,
                            input logic [SHIFT_REG_W-1:0] lo,
                            input logic [SHIFT_REG_W-1:0] hi);
      csr_write(REG_MODE, CSR_DATA_W'(md));
      csr_write(REG_KEY_LENGTH, CSR_DATA_W'(len));
      csr_write(REG_SHIFTS_LOW, CSR_DATA_W'(lo));
      csr_write(REG_SHIFTS_HIGH, CSR_DATA_W'(hi));
      setting_count++;
   endtask

   // pauses the sender until every result is back, plus pipeline drain;
   // checked at the falling edge so the driver's updates have settled
   task automatic wait_idle();
      while (plain_queue.size() != 0 || req_tvalid || cipher_due.size() != 0)
         @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic push_char(input logic [CHAR_W-1:0] ch, input logic last);
      plain_queue.insert(plain_queue.size(), '{ch: ch, last: last});
   endtask

   task automatic push_text(input string s, input logic last_at_end);
      for (int i = 0; i < s.len(); i++)
         push_char(s[i], last_at_end && (i == s.len() - 1));
   endtask

   function automatic logic [SHIFT_REG_W-1:0] random_shifts();
      logic [SHIFT_REG_W-1:0] v;
      case ($urandom_range(0, 7))
         0: v = '0;
         1: v = '1;
         default:
            for (int k = 0; k < SHIFT_REG_W / SHIFT_W; k++)
               v[k*SHIFT_W +: SHIFT_W] = SHIFT_W'($urandom_range(0, 31));
      endcase
      return v;
   endfunction

   function automatic logic [CHAR_W-1:0] random_char(input bit noisy);
      int pick;
      pick = noisy ? 99 : $urandom_range(0, 99);
      if (pick < 40)
         return CHAR_UP_A + CHAR_W'($urandom_range(0, 25));
      else if (pick < 75)
         return CHAR_LO_A + CHAR_W'($urandom_range(0, 25));
      else if (pick < 90)
         return CHAR_ZERO + CHAR_W'($urandom_range(0, 9));
      return CHAR_W'($urandom_range(0, 255));
   endfunction

   // strings of mixed text, a few of pure noise; the final one may be cut
   // short so the key position carries into the next key setting
   task automatic queue_strings(input int count);
      int  len;
      bit  noisy;
      while (count > 0) begin
         len = $urandom_range(1, 40);
         noisy = ($urandom_range(0, 7) == 0);
         for (int i = 0; i < len && count > 0; i++) begin
            push_char(random_char(noisy), (i == len - 1));
            count--;
         end
      end
   endtask

   initial begin
      logic [KEY_LEN_W-1:0] len;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset key: zero shifts, so letters only fold case; bounds of each class
      push_text("Az09@[`{", 1'b1);
      push_char(8'h00, 1'b0);
      push_char(8'h7f, 1'b0);
      push_char(8'h80, 1'b0);
      push_char(8'hff, 1'b1);
      wait_idle();

      // decrypt, zero length acts as one, shift 31 reduces to 5
      key_setup(MODE_DECRYPT, 5'd0, 40'h00_0000_001f, '1);
      push_text("AbZ", 1'b1);
      wait_idle();

      // shortened key mid-string: position 6 is past the new length of two,
      // its shift is still used and the position then wraps to zero
      key_setup(MODE_ENCRYPT, 5'd16, 40'h01_c000_7f59, '0);
      push_text("HeLLo1", 1'b0);
      wait_idle();
      csr_write(REG_KEY_LENGTH, CSR_DATA_W'(2));
      push_text("QRS", 1'b1);
      wait_idle();

      // random phases; the first two pin the extremes
      for (int p = 0; p < 8; p++) begin
         case (p)
            0: key_setup(MODE_DECRYPT, 5'd31, '1, '1);
            1: key_setup(MODE_ENCRYPT, 5'd16, random_shifts(), random_shifts());
            default: begin
               case ($urandom_range(0, 5))
                  0: len = 5'd0;
                  1: len = 5'd1;
                  2: len = 5'd16;
                  3: len = 5'd31;
                  default: len = KEY_LEN_W'($urandom_range(2, 15));
               endcase
               key_setup(1'($urandom_range(0, 1)), len, random_shifts(), random_shifts());
            end
         endcase
         queue_strings(100);
         wait_idle();
      end

      repeat (10) @(posedge clock);
      $display("run covered %0d characters (%0d emitted, %0d skipped) under %0d key settings",
               sent_count, emitted_count, skipped_count, setting_count);
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

FILE: vigenere_stream_cipher.f
sv/vsc_pkg.sv
sv/vsc_xform.sv
sv/vigenere_stream_cipher.sv
test/tb_top.sv
